/* rtl/hqja_pkg.sv */
`default_nettype none

package hqja_pkg;

    // Default sizes of the queue.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Widest tag and count over the whole legal range of CAPACITY (up to 1024 entries).
    localparam int MAX_TAG_W = 10;
    localparam int MAX_CNT_W = 11;

    // Operation carried by an input beat.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2,
        OP_JUMP  = 2'd3
    } opcode_t;

    // Status carried by a result beat.
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2,
        ERR_STALE = 2'd3
    } err_t;

    // Operation that every cell of the order chain applies.
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2,
        CMD_JUMP = 2'd3
    } cell_cmd_t;

    // Control that is broadcast to all cells of the chain.
    typedef struct packed {
        cell_cmd_t              cmd;
        logic [MAX_CNT_W-1:0]   count;
        logic [MAX_CNT_W-1:0]   old_pos;
        logic [MAX_CNT_W-1:0]   target_pos;
        logic [MAX_TAG_W-1:0]   tag;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/hqja_ram.sv */
`default_nettype none

module hqja_ram #(
    parameter int WIDTH = hqja_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = hqja_pkg::CAPACITY_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/hqja_cell.sv */
`default_nettype none

module hqja_cell #(
    parameter int TAG_W = 6,
    parameter int INDEX = 0
) (
    input  wire logic                 clk,
    input  wire hqja_pkg::cell_ctrl_t ctrl,
    input  wire logic [TAG_W-1:0]     prev_tag,
    input  wire logic [TAG_W-1:0]     next_tag,
    output logic      [TAG_W-1:0]     tag,
    output logic                      match
);

    localparam int CW = hqja_pkg::MAX_CNT_W;
    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;

    // Each cell holds the tag at one queue position and takes a neighbor's tag on a shift.
    always_comb
    begin
        tag_next = tag_reg;
        case (ctrl.cmd)
            hqja_pkg::CMD_HOLD:
            begin
                tag_next = tag_reg;
            end
            hqja_pkg::CMD_PUSH:
            begin
                if (ctrl.count == IDX)
                begin
                    tag_next = ctrl.tag[TAG_W-1:0];
                end
            end
            hqja_pkg::CMD_POP:
            begin
                tag_next = next_tag;
            end
            hqja_pkg::CMD_JUMP:
            begin
                if (ctrl.target_pos == IDX)
                begin
                    tag_next = ctrl.tag[TAG_W-1:0];
                end
                else if ((IDX > ctrl.target_pos) && (IDX <= ctrl.old_pos))
                begin
                    tag_next = prev_tag;
                end
            end
            default:
            begin
                tag_next = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tag   = tag_reg;
    assign match = (IDX < ctrl.count) && (tag_reg == ctrl.tag[TAG_W-1:0]);

endmodule

`default_nettype wire

/* rtl/handle_queue_with_jump_ahead.sv */
`default_nettype none

// Channel  Handshake              Fields
// -------  ---------------------  ---------------------------------------------------------
// input    in_valid / in_ready    opcode, push_value, item_handle, jump_distance
// output   out_valid / out_ready  result_value, new_handle, item_position, occupancy,
//                                 error_code
//
// One operation is in flight at a time. A push, and a pop on an empty queue, finish in the
// execute state after accept; a pop adds a pop-read state for the registered read of the
// value memory, and a query or jump adds a move state, since the found position of the tag
// compare across the cell chain is registered before the shift. Reset clears the occupancy
// count and the live flag of every tag; there is no clearing pass. A stalled output holds
// the finished beat while the next beat is already accepted.

module handle_queue_with_jump_ahead #(
    parameter int CAPACITY   = hqja_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = hqja_pkg::DATA_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] push_value,
    input  wire logic [5:0]  item_handle,
    input  wire logic [6:0]  jump_distance,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result_value,
    output logic [5:0]       new_handle,
    output logic [5:0]       item_position,
    output logic [6:0]       occupancy,
    output logic [1:0]       error_code
);

    // Tag width, count width and the width used for the jump arithmetic.
    localparam int TW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int DW  = (TW > 7) ? TW : 7;
    localparam int MTW = hqja_pkg::MAX_TAG_W;
    localparam int MCW = hqja_pkg::MAX_CNT_W;

    // Sequencer: take a beat, execute it on the chain, then finish a pop or a locate.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_POPRD = 4'b0100,
        S_MOVE  = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    // Captured input beat.
    hqja_pkg::opcode_t     op_reg;
    logic [31:0]           value_reg;
    logic [5:0]            handle_reg;
    logic [6:0]            dist_reg;

    // Queue bookkeeping.
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CAPACITY-1:0]   tag_in_use_reg;
    logic [CAPACITY-1:0]   tag_in_use_next;
    logic                  free_any_reg;
    logic [TW-1:0]         free_tag_reg;
    logic                  free_any;
    logic [TW-1:0]         free_tag;

    // Result of a locate, held for the move cycle.
    logic                  live_reg;
    logic                  live_next;
    logic [TW-1:0]         pos_reg;
    logic [TW-1:0]         pos_next;

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_load;
    logic [31:0]           result_value_reg;
    logic [31:0]           result_value_next;
    logic [5:0]            new_handle_reg;
    logic [5:0]            new_handle_next;
    logic [5:0]            item_position_reg;
    logic [5:0]            item_position_next;
    logic [6:0]            occupancy_reg;
    hqja_pkg::err_t        error_code_reg;
    hqja_pkg::err_t        error_code_next;

    // Cell chain.
    hqja_pkg::cell_ctrl_t  ctrl;
    logic [TW-1:0]         tag_w [CAPACITY];
    logic [CAPACITY-1:0]   match_w;
    logic                  found;
    logic [TW-1:0]         found_pos;

    // Value memory, indexed by tag.
    logic                  ram_we;
    logic                  ram_re;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Helper signals.
    logic                  go;
    logic                  full;
    logic                  handle_in_range;
    logic                  handle_in_use;
    logic [TW-1:0]         handle_tag;
    logic [TW-1:0]         target;
    logic [DW-1:0]         old_d;
    logic [DW-1:0]         dist_d;
    logic [DATA_WIDTH+31:0] push_ext;
    logic [DATA_WIDTH+31:0] rdata_ext;
    logic [TW+5:0]         free_ext;
    logic [TW+5:0]         pos_ext;
    logic [TW+5:0]         target_ext;
    logic [CW+6:0]         count_ext;

    // A result may be written when the output register is empty or is being taken now.
    assign go       = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign full     = (count_reg == CW'(CAPACITY));

    // A handle beyond the tag space is never live.
    assign handle_in_range = (32'(handle_reg) < 32'(CAPACITY));
    assign handle_tag      = TW'(handle_reg);
    assign handle_in_use   = handle_in_range && tag_in_use_reg[handle_tag];

    // Clamped destination of a jump.
    assign old_d  = DW'(pos_reg);
    assign dist_d = DW'(dist_reg);
    assign target = (old_d < dist_d) ? '0 : TW'(old_d - dist_d);

    assign push_ext   = {{DATA_WIDTH{1'b0}}, value_reg};
    assign rdata_ext  = {32'b0, ram_rdata};
    assign free_ext   = {6'b0, free_tag_reg};
    assign pos_ext    = {6'b0, pos_reg};
    assign target_ext = {6'b0, target};
    assign count_ext  = {7'b0, count_next};

    // Lowest free tag, taken from the live flags of the previous cycle. Every operation
    // spends its accept cycle in the idle state before it executes, so it is always current.
    always_comb
    begin
        free_any = 1'b0;
        free_tag = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!tag_in_use_reg[i])
            begin
                free_any = 1'b1;
                free_tag = TW'(i);
            end
        end
    end

    // Position of the matching cell; at most one live cell holds a given tag.
    always_comb
    begin
        found_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_w[i])
            begin
                found_pos = found_pos | TW'(i);
            end
        end
    end
    assign found = |match_w;

    // Main sequencer and datapath control.
    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        tag_in_use_next    = tag_in_use_reg;
        live_next          = live_reg;
        pos_next           = pos_reg;
        ram_we             = 1'b0;
        ram_re             = 1'b0;
        out_load           = 1'b0;
        result_value_next  = '0;
        new_handle_next    = '0;
        item_position_next = '0;
        error_code_next    = hqja_pkg::ERR_OK;

        ctrl.cmd           = hqja_pkg::CMD_HOLD;
        ctrl.count         = MCW'(count_reg);
        ctrl.old_pos       = MCW'(pos_reg);
        ctrl.target_pos    = MCW'(target);
        ctrl.tag           = MTW'(handle_tag);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (op_reg)
                    hqja_pkg::OP_PUSH:
                    begin
                        if (go)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (full || !free_any_reg)
                            begin
                                error_code_next = hqja_pkg::ERR_FULL;
                            end
                            else
                            begin
                                ctrl.cmd                      = hqja_pkg::CMD_PUSH;
                                ctrl.tag                      = MTW'(free_tag_reg);
                                tag_in_use_next[free_tag_reg] = 1'b1;
                                ram_we                        = 1'b1;
                                count_next                    = count_reg + 1'b1;
                                new_handle_next               = free_ext[5:0];
                            end
                        end
                    end

                    hqja_pkg::OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            if (go)
                            begin
                                out_load        = 1'b1;
                                error_code_next = hqja_pkg::ERR_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            // The whole chain shifts toward the head while the head's value is read; the read
                            // data is registered in the memory and loaded into the output in the pop-read state.
                            ctrl.cmd                  = hqja_pkg::CMD_POP;
                            tag_in_use_next[tag_w[0]] = 1'b0;
                            ram_re                    = 1'b1;
                            count_next                = count_reg - 1'b1;
                            state_next                = S_POPRD;
                        end
                    end

                    default:
                    begin
                        // Query or jump: every cell compares its tag with the handle.
                        live_next  = handle_in_use && found;
                        pos_next   = found_pos;
                        state_next = S_MOVE;
                    end
                endcase
            end

            S_POPRD:
            begin
                if (go)
                begin
                    out_load          = 1'b1;
                    result_value_next = rdata_ext[31:0];
                    state_next        = S_IDLE;
                end
            end

            S_MOVE:
            begin
                if (go)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if ((op_reg == hqja_pkg::OP_JUMP) && (dist_reg == '0))
                    begin
                        // A zero-distance jump moves nothing, gives a live item's position and no error.
                        if (live_reg)
                        begin
                            item_position_next = pos_ext[5:0];
                        end
                    end
                    else if (!live_reg)
                    begin
                        error_code_next = hqja_pkg::ERR_STALE;
                    end
                    else if (op_reg == hqja_pkg::OP_QUERY)
                    begin
                        item_position_next = pos_ext[5:0];
                    end
                    else
                    begin
                        // The item lands at the target and the passed items slide back.
                        ctrl.cmd           = hqja_pkg::CMD_JUMP;
                        item_position_next = target_ext[5:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            tag_in_use_reg <= '0;
            free_any_reg   <= 1'b0;
            live_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            tag_in_use_reg <= tag_in_use_next;
            free_any_reg   <= free_any;
            live_reg       <= live_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        free_tag_reg <= free_tag;
        pos_reg      <= pos_next;
        if (in_valid && in_ready)
        begin
            op_reg     <= hqja_pkg::opcode_t'(opcode);
            value_reg  <= push_value;
            handle_reg <= item_handle;
            dist_reg   <= jump_distance;
        end
        if (out_load)
        begin
            result_value_reg  <= result_value_next;
            new_handle_reg    <= new_handle_next;
            item_position_reg <= item_position_next;
            occupancy_reg     <= count_ext[6:0];
            error_code_reg    <= error_code_next;
        end
    end

    // Chain of cells, head at index 0. Each cell sees its neighbors; an end cell sees itself where none is.
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic [TW-1:0] prev_w;
        logic [TW-1:0] next_w;

        if (gi == 0)
        begin : g_head
            assign prev_w = tag_w[gi];
        end
        else
        begin : g_body
            assign prev_w = tag_w[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_tail
            assign next_w = tag_w[gi];
        end
        else
        begin : g_mid
            assign next_w = tag_w[gi+1];
        end

        hqja_cell #(
            .TAG_W (TW),
            .INDEX (gi)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .prev_tag (prev_w),
            .next_tag (next_w),
            .tag      (tag_w[gi]),
            .match    (match_w[gi])
        );
    end

    // Value memory: written by a push at the new tag, read by a pop at the head tag.
    hqja_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_tag_reg),
        .wdata (push_ext[DATA_WIDTH-1:0]),
        .re    (ram_re),
        .raddr (tag_w[0]),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign result_value  = result_value_reg;
    assign new_handle    = new_handle_reg;
    assign item_position = item_position_reg;
    assign occupancy     = occupancy_reg;
    assign error_code    = error_code_reg;

    // The number of live tags always equals the number of queued items.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tag_in_use_reg) == int'(count_reg))
        else $error("live tag count differs from queue occupancy");

    // The queue never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("queue occupancy beyond capacity");

    // A pop on a non-empty queue removes exactly one item and waits for the read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg == hqja_pkg::OP_POP && count_reg != '0) |=>
        (state_reg == S_POPRD && count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shift out exactly one item");

    // Only one operation is in flight: an accepted beat closes the input channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an operation is in flight");

endmodule

`default_nettype wire
